// ===== hw/rtl/cbc_pkg.sv =====
package cbc_pkg;

  localparam int unsigned MAX_WIDTH_DEF = 1024;
  localparam int unsigned HEIGHT_CAP    = 1024;
  localparam int unsigned QUEUE_DEPTH   = 2;
  // internal width for positions and frame sizes
  localparam int unsigned POS_W         = 14;
  localparam int unsigned ROW_W         = 11;
  localparam int unsigned DIM_W         = 11;

  typedef struct packed {
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic [7:0]        divider;
    logic [2:0][23:0]  coef;    // coef[col], row r at bits 8r
  } cfg_t;

  // one output pixel worth of work
  typedef struct packed {
    logic [2:0][2:0][7:0] taps;  // taps[row][col]
    logic [2:0][2:0]      mask;  // tap lies inside the frame
    logic                 eor;
    logic                 eof;
  } job_t;

  function automatic logic signed [7:0] coef_at(cfg_t cfg, logic [1:0] row, logic [1:0] col);
    logic [23:0] column;
    column = cfg.coef[col];
    return $signed(column[8*row +: 8]);
  endfunction

  function automatic logic signed [11:0] coef_sum(cfg_t cfg);
    logic signed [11:0] acc;
    logic [7:0]         b;
    acc = '0;
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        b = cfg.coef[c][8*r +: 8];
        acc = acc + {{4{b[7]}}, b};
      end
    end
    return acc;
  endfunction

endpackage

// ===== hw/rtl/cbc_front.sv =====
module cbc_front #(
  parameter int unsigned MaxWidth = cbc_pkg::MAX_WIDTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cbc_pkg::cfg_t cfg_i,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic          kind_i,
  input  logic [7:0]    pixel_i,
  output cbc_pkg::job_t job_o,
  output logic          job_valid_o,
  input  logic          job_full_i
);
  import cbc_pkg::*;

  localparam int unsigned CW    = $clog2(MaxWidth);
  localparam int unsigned CNT_W = CW + 1;

  typedef enum logic [3:0] {
    F_CLEAR = 4'b0001,
    F_IDLE  = 4'b0010,
    F_READ  = 4'b0100,
    F_PUSH  = 4'b1000
  } fstate_e;

  fstate_e state_q, state_d;

  logic [7:0] upper_mem [MaxWidth];
  logic [7:0] lower_mem [MaxWidth];
  logic [7:0] up_rd_q, lo_rd_q;

  logic [CNT_W-1:0] clr_q;
  logic [CW-1:0]    col_q, c_q;
  logic [ROW_W-1:0] row_q, r_q;
  logic [7:0]       px_q;
  logic [2:0][2:0][7:0] win_q, win_d;
  job_t job_q, job_d;
  logic emit_q, emit_d;

  logic [POS_W-1:0] w_eff, h_eff, w_ext, h_ext;
  logic [POS_W-1:0] col0, row0, col1, row1, colp, col_n, row_n;
  logic [7:0]       px;
  logic             accept;

  always_comb begin
    w_ext = POS_W'(cfg_i.width);
    h_ext = POS_W'(cfg_i.height);
    if (w_ext == '0) w_eff = POS_W'(1);
    else if (w_ext > POS_W'(MaxWidth)) w_eff = POS_W'(MaxWidth);
    else w_eff = w_ext;
    if (h_ext == '0) h_eff = POS_W'(1);
    else if (h_ext > POS_W'(HEIGHT_CAP)) h_eff = POS_W'(HEIGHT_CAP);
    else h_eff = h_ext;
  end

  assign accept     = in_valid_i && (state_q == F_IDLE);
  assign in_stall_o = (state_q != F_IDLE);

  // position of this item and of the next one
  always_comb begin
    col0 = POS_W'(col_q);
    row0 = POS_W'(row_q);
    col1 = col0;
    row1 = row0;
    if (col0 >= w_eff) begin
      col1 = '0;
      row1 = row0 + POS_W'(1);
    end
    if (row1 > h_eff + POS_W'(1)) begin
      col1 = '0;
      row1 = '0;
    end
    px = (kind_i || (row1 >= h_eff)) ? 8'd0 : pixel_i;
    colp  = col1 + POS_W'(1);
    col_n = colp;
    row_n = row1;
    if (row1 >= h_eff + POS_W'(1)) begin
      col_n = '0;
      row_n = '0;
    end else if (colp >= w_eff) begin
      col_n = '0;
      row_n = row1 + POS_W'(1);
    end
  end

  // line stores: registered read at accept, write back in the F_READ cycle that follows
  always_ff @(posedge clk_i) begin
    if (accept) begin
      up_rd_q <= upper_mem[col1[CW-1:0]];
      lo_rd_q <= lower_mem[col1[CW-1:0]];
    end
    if (state_q == F_CLEAR) begin
      upper_mem[clr_q[CW-1:0]] <= 8'd0;
      lower_mem[clr_q[CW-1:0]] <= 8'd0;
    end else if (state_q == F_READ) begin
      upper_mem[c_q] <= lo_rd_q;
      lower_mem[c_q] <= px_q;
    end
  end

  // window shift and job build
  always_comb begin
    logic signed [POS_W:0] cx, cy, x, y, ws, hs;
    ws = $signed({1'b0, w_eff});
    hs = $signed({1'b0, h_eff});
    win_d = win_q;
    for (int i = 0; i < 3; i++) begin
      win_d[i][0] = win_q[i][1];
      win_d[i][1] = win_q[i][2];
    end
    win_d[0][2] = up_rd_q;
    win_d[1][2] = lo_rd_q;
    win_d[2][2] = px_q;
    if (c_q == '0) begin
      cx = ws - (POS_W+1)'(1);
      cy = $signed({1'b0, POS_W'(r_q)}) - (POS_W+1)'(2);
    end else begin
      cx = $signed({1'b0, POS_W'(c_q)}) - (POS_W+1)'(1);
      cy = $signed({1'b0, POS_W'(r_q)}) - (POS_W+1)'(1);
    end
    emit_d     = (cy >= 0) && (cy < hs);
    job_d.taps = win_d;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        x = cx - (POS_W+1)'(1) + (POS_W+1)'(j);
        y = cy - (POS_W+1)'(1) + (POS_W+1)'(i);
        job_d.mask[i][j] = (x >= 0) && (x < ws) && (y >= 0) && (y < hs);
      end
    end
    job_d.eor = (cx == ws - (POS_W+1)'(1));
    job_d.eof = job_d.eor && (cy == hs - (POS_W+1)'(1));
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_CLEAR: if (clr_q == CNT_W'(MaxWidth - 1)) state_d = F_IDLE;
      F_IDLE:  if (accept) state_d = F_READ;
      F_READ:  state_d = F_PUSH;
      F_PUSH:  if (!emit_q || !job_full_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_CLEAR;
      clr_q   <= '0;
      col_q   <= '0;
      row_q   <= '0;
      win_q   <= '0;
      emit_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == F_CLEAR) clr_q <= clr_q + CNT_W'(1);
      if (accept) begin
        col_q <= col_n[CW-1:0];
        row_q <= row_n[ROW_W-1:0];
      end
      if (state_q == F_READ) begin
        win_q  <= win_d;
        emit_q <= emit_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      c_q  <= col1[CW-1:0];
      r_q  <= row1[ROW_W-1:0];
      px_q <= px;
    end
    if (state_q == F_READ) job_q <= job_d;
  end

  assign job_o       = job_q;
  assign job_valid_o = (state_q == F_PUSH) && emit_q;

endmodule

// ===== hw/rtl/cbc_queue.sv =====
module cbc_queue #(
  parameter int unsigned Depth = cbc_pkg::QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cbc_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output cbc_pkg::job_t job_o,
  output logic          empty_o
);
  import cbc_pkg::*;

  localparam int unsigned PW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned NW = $clog2(Depth + 1);

  job_t            entry_q [Depth];
  logic [PW-1:0]   wr_q, rd_q;
  logic [NW-1:0]   cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == NW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = entry_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) entry_q[wr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PW'(Depth - 1)) ? '0 : wr_q + PW'(1);
      if (do_pop)  rd_q <= (rd_q == PW'(Depth - 1)) ? '0 : rd_q + PW'(1);
      if (do_push && !do_pop) cnt_q <= cnt_q + NW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - NW'(1);
    end
  end

endmodule

// ===== hw/rtl/cbc_back.sv =====
module cbc_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cbc_pkg::cfg_t cfg_i,
  input  cbc_pkg::job_t job_i,
  input  logic          job_empty_i,
  output logic          job_pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [7:0]    out_pixel_o,
  output logic          end_of_row_o,
  output logic          end_of_frame_o
);
  import cbc_pkg::*;

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_MUL  = 5'b00010,
    B_DIV  = 5'b00100,
    B_ACC  = 5'b01000,
    B_DONE = 5'b10000
  } bstate_e;

  bstate_e state_q;
  job_t    job_q;
  logic [1:0] ti_q, tj_q;
  logic [7:0] total_q;
  logic signed [16:0] prod_q, prod_d;
  logic        neg_q;
  logic [14:0] dvd_q, dvd_d;
  logic [10:0] rem_q, rem_d;
  logic [2:0]  step_q;
  logic signed [11:0] sum_q;
  logic [10:0] dsor;
  logic        div_en, last_tap, out_load;
  logic [7:0]  total_d;
  logic [7:0]  px;
  logic signed [7:0] coef;
  logic [16:0] mag;

  assign div_en = (cfg_i.divider != 8'd0) || (sum_q > 12'sd1);
  assign dsor   = (cfg_i.divider != 8'd0) ? {3'b0, cfg_i.divider} : sum_q[10:0];

  assign px       = job_q.taps[ti_q][tj_q];
  assign coef     = coef_at(cfg_i, ti_q, tj_q);
  assign last_tap = (ti_q == 2'd2) && (tj_q == 2'd2);

  always_comb begin
    logic signed [16:0] a, b;
    a      = {9'b0, px};
    b      = {{9{coef[7]}}, coef};
    prod_d = a * b;
    mag    = prod_d[16] ? 17'(-prod_d) : prod_d;
  end

  // three restoring steps per cycle
  always_comb begin
    logic [11:0] r;
    logic [14:0] d;
    r = {1'b0, rem_q};
    d = dvd_q;
    for (int k = 0; k < 3; k++) begin
      r = {r[10:0], d[14]};
      d = {d[13:0], 1'b0};
      if (r >= {1'b0, dsor}) begin
        r    = r - {1'b0, dsor};
        d[0] = 1'b1;
      end
    end
    rem_d = r[10:0];
    dvd_d = d;
  end

  // add and clamp
  always_comb begin
    logic signed [17:0] addend, tot;
    if (div_en) addend = neg_q ? -$signed({3'b0, dvd_q}) : $signed({3'b0, dvd_q});
    else addend = {prod_q[16], prod_q};
    tot = $signed({10'b0, total_q}) + addend;
    if (tot < 0) total_d = 8'd0;
    else if (tot > 18'sd255) total_d = 8'd255;
    else total_d = tot[7:0];
  end

  assign job_pop_o = (state_q == B_IDLE) && !job_empty_i;
  assign out_load  = (state_q == B_DONE) && (!out_valid_o || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_o <= 1'b0;
      sum_q       <= '0;
    end else begin
      sum_q <= coef_sum(cfg_i);
      if (out_load) out_valid_o <= 1'b1;
      else if (!out_stall_i) out_valid_o <= 1'b0;
      unique case (state_q)
        B_IDLE: if (!job_empty_i) state_q <= B_MUL;
        B_MUL: begin
          if (job_q.mask[ti_q][tj_q]) state_q <= div_en ? B_DIV : B_ACC;
          else if (last_tap) state_q <= B_DONE;
        end
        B_DIV: if (step_q == 3'd4) state_q <= B_ACC;
        B_ACC: state_q <= last_tap ? B_DONE : B_MUL;
        B_DONE: if (out_load) state_q <= B_IDLE;
        default: state_q <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      B_IDLE: begin
        job_q   <= job_i;
        ti_q    <= 2'd0;
        tj_q    <= 2'd0;
        total_q <= 8'd0;
      end
      B_MUL: begin
        prod_q <= prod_d;
        neg_q  <= prod_d[16];
        dvd_q  <= mag[14:0];
        rem_q  <= '0;
        step_q <= '0;
        if (!job_q.mask[ti_q][tj_q] && !last_tap) begin
          tj_q <= (tj_q == 2'd2) ? 2'd0 : tj_q + 2'd1;
          if (tj_q == 2'd2) ti_q <= ti_q + 2'd1;
        end
      end
      B_DIV: begin
        dvd_q  <= dvd_d;
        rem_q  <= rem_d;
        step_q <= step_q + 3'd1;
      end
      B_ACC: begin
        total_q <= total_d;
        if (!last_tap) begin
          tj_q <= (tj_q == 2'd2) ? 2'd0 : tj_q + 2'd1;
          if (tj_q == 2'd2) ti_q <= ti_q + 2'd1;
        end
      end
      B_DONE: begin
        if (out_load) begin
          out_pixel_o    <= total_q;
          end_of_row_o   <= job_q.eor;
          end_of_frame_o <= job_q.eof;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/conv3x3_per_tap_divide_clamp.sv =====
// front: accept, line store read, queue push; back: take the job, then per tap
// multiply (a skipped tap stops there), divide in five radix-8 divider steps if
// division is on, add; then load the output register; the center tap is never
// skipped; the shared tap divider limits the rate; the front takes new requests
// while the back is busy, until the queue is full
// reset: asynchronous, active low; a clearing pass then zeroes both line stores
// with in_stall_o high, config writes are taken meanwhile
module conv3x3_per_tap_divide_clamp #(
  parameter int unsigned MaxWidth   = cbc_pkg::MAX_WIDTH_DEF,
  parameter int unsigned QueueDepth = cbc_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // pixel requests
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [7:0]  pixel_i,
  // filtered pixel requests
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_pixel_o,
  output logic        end_of_row_o,
  output logic        end_of_frame_o
);
  import cbc_pkg::*;

  localparam logic [2:0] REG_WIDTH   = 3'd0;
  localparam logic [2:0] REG_HEIGHT  = 3'd1;
  localparam logic [2:0] REG_DIVIDER = 3'd2;
  localparam logic [2:0] REG_COEF0   = 3'd3;
  localparam logic [2:0] REG_COEF1   = 3'd4;
  localparam logic [2:0] REG_COEF2   = 3'd5;

  cfg_t cfg_q;
  logic [2:0] reg_idx;
  logic       wr_en;

  // front to back handoff
  job_t f_job, q_job;
  logic f_valid, q_full, q_empty, b_pop;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width   <= DIM_W'(640);
      cfg_q.height  <= DIM_W'(480);
      cfg_q.divider <= '0;
      cfg_q.coef    <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_WIDTH:   cfg_q.width   <= pwdata[DIM_W-1:0];
        REG_HEIGHT:  cfg_q.height  <= pwdata[DIM_W-1:0];
        REG_DIVIDER: cfg_q.divider <= pwdata[7:0];
        REG_COEF0:   cfg_q.coef[0] <= pwdata[23:0];
        REG_COEF1:   cfg_q.coef[1] <= pwdata[23:0];
        REG_COEF2:   cfg_q.coef[2] <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WIDTH:   prdata = 32'(cfg_q.width);
      REG_HEIGHT:  prdata = 32'(cfg_q.height);
      REG_DIVIDER: prdata = 32'(cfg_q.divider);
      REG_COEF0:   prdata = 32'(cfg_q.coef[0]);
      REG_COEF1:   prdata = 32'(cfg_q.coef[1]);
      REG_COEF2:   prdata = 32'(cfg_q.coef[2]);
      default:     prdata = '0;
    endcase
  end

  // front: position tracking, line stores, window, tap masks
  cbc_front #(.MaxWidth(MaxWidth)) u_front (
    .clk_i,
    .rst_ni,
    .cfg_i       (cfg_q),
    .in_valid_i,
    .in_stall_o,
    .kind_i,
    .pixel_i,
    .job_o       (f_job),
    .job_valid_o (f_valid),
    .job_full_i  (q_full)
  );

  // short queue so the front keeps taking pixels while the back divides
  cbc_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (f_valid),
    .job_i   (f_job),
    .full_o  (q_full),
    .pop_i   (b_pop),
    .job_o   (q_job),
    .empty_o (q_empty)
  );

  // back: per-tap multiply, divide, clamped accumulate, output register
  cbc_back u_back (
    .clk_i,
    .rst_ni,
    .cfg_i       (cfg_q),
    .job_i       (q_job),
    .job_empty_i (q_empty),
    .job_pop_o   (b_pop),
    .out_valid_o,
    .out_stall_i,
    .out_pixel_o,
    .end_of_row_o,
    .end_of_frame_o
  );

endmodule

// ===== hw/rtl/cbc_checker.sv =====
module cbc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_pixel_o,
  input logic       end_of_row_o,
  input logic       end_of_frame_o
);

  // a held request keeps its valid and payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("out valid dropped under stall");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_pixel_o) && $stable(end_of_row_o)
      && $stable(end_of_frame_o))
    else $error("out payload changed under stall");

  // frame end is always a row end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_frame_o |-> end_of_row_o)
    else $error("end of frame without end of row");

  // line stores are cleared before any pixel is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> in_stall_o)
    else $error("pixel taken during clearing pass");

endmodule

bind conv3x3_per_tap_divide_clamp cbc_checker u_cbc_checker (.*);

// ===== bench/tb.sv =====
module tb;
  import cbc_pkg::*;

  // register byte addresses on the config port
  localparam logic [4:0] ADDR_WIDTH   = 5'd0;
  localparam logic [4:0] ADDR_HEIGHT  = 5'd4;
  localparam logic [4:0] ADDR_DIVIDER = 5'd8;
  localparam logic [4:0] ADDR_COEF0   = 5'd12;
  localparam logic [4:0] ADDR_COEF1   = 5'd16;
  localparam logic [4:0] ADDR_COEF2   = 5'd20;

  // request kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // idle cycles after the last result, longer than the slowest request
  localparam int DRAIN_CYCLES = 100;
  localparam int LONG_HOLD    = 600;

  typedef struct packed {
    logic       kind;
    logic [7:0] pixel;
  } pix_req_t;

  typedef struct packed {
    logic [7:0] out_pixel;
    logic       eor;
    logic       eof;
  } filt_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        kind = 1'b0;
  logic [7:0]  pixel = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_pixel;
  logic        end_of_row, end_of_frame;

  conv3x3_per_tap_divide_clamp DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .kind_i(kind), .pixel_i(pixel),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_pixel_o(out_pixel),
    .end_of_row_o(end_of_row), .end_of_frame_o(end_of_frame)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 0;
  end

  // pending pixel requests and expected filtered pixels
  pix_req_t  pending_pix[$];
  filt_res_t filtered_q[$];
  int        errors = 0;
  int        results_seen = 0;
  int        frames_sent = 0;
  int        phases_run = 0;

  // shadow of the register file
  logic [10:0] sh_width = 11'd640, sh_height = 11'd480;
  logic [7:0]  sh_divider = '0;
  logic [23:0] sh_coef[3] = '{default: '0};

  // shadow of the datapath state
  logic [7:0] upper_line[MAX_WIDTH_DEF];
  logic [7:0] lower_line[MAX_WIDTH_DEF];
  logic [7:0] win[3][3];
  int         pos_col = 0, pos_row = 0;

  initial begin
    foreach (upper_line[i]) begin
      upper_line[i] = '0;
      lower_line[i] = '0;
    end
    foreach (win[i, j]) win[i][j] = '0;
  end

  function automatic int coef_tap(int r, int c);
    logic [7:0] b;
    b = sh_coef[c][8*r +: 8];
    return int'($signed(b));
  endfunction

  // advance the window by one request and queue the filtered pixel it releases
  function automatic void filter_step(logic k, logic [7:0] p);
    int w, h, c, r, cx, cy, csum, total, x, y, prod;
    logic [7:0] px;
    filt_res_t res;
    w = sh_width;
    h = sh_height;
    if (w < 1) w = 1;
    if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
    if (h < 1) h = 1;
    if (h > HEIGHT_CAP) h = HEIGHT_CAP;
    // renormalize position against the current frame size
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row++;
    end
    if (pos_row > h + 1) begin
      pos_row = 0;
      pos_col = 0;
    end
    c = pos_col;
    r = pos_row;
    // flushes and anything past the last row shift in zeros
    px = (k == KIND_FLUSH || r >= h) ? 8'd0 : p;
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = upper_line[c];
    win[1][2] = lower_line[c];
    win[2][2] = px;
    upper_line[c] = lower_line[c];
    lower_line[c] = px;
    if (r >= h + 1) begin
      pos_row = 0;
      pos_col = 0;
    end else begin
      pos_col++;
      if (pos_col >= w) begin
        pos_col = 0;
        pos_row++;
      end
    end
    // window center lags one row and one pixel
    if (c == 0) begin
      cx = w - 1;
      cy = r - 2;
    end else begin
      cx = c - 1;
      cy = r - 1;
    end
    if (cy < 0 || cy >= h) return;
    csum = 0;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) csum += coef_tap(i, j);
    total = 0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        x = cx - 1 + j;
        y = cy - 1 + i;
        if (x < 0 || x >= w || y < 0 || y >= h) continue;
        prod = int'(win[i][j]) * coef_tap(i, j);
        // signed division truncates toward zero
        if (sh_divider != 0) prod = prod / int'(sh_divider);
        else if (csum > 1) prod = prod / csum;
        total += prod;
        if (total > 255) total = 255;
        else if (total < 0) total = 0;
      end
    end
    res.out_pixel = total[7:0];
    res.eor = (cx == w - 1);
    res.eof = (cx == w - 1) && (cy == h - 1);
    filtered_q.push_back(res);
  endfunction

  // sender: bursts of random length with random gaps
  int burst_left = 4, gap_left = 0;
  always @(posedge clk) begin
    pix_req_t nxt;
    if (in_valid && !in_stall) filter_step(kind, pixel);
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_pix.size() > 0) begin
        nxt = pending_pix.pop_front();
        in_valid <= 1'b1;
        kind <= nxt.kind;
        pixel <= nxt.pixel;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          // some bursts run back to back
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: a random stall pattern, redrawn each time mode_age wraps, plus requested long hold-offs
  int hold_req = 0, hold_ack = 0, hold_left = 0, stall_mode = 0, mode_age = 0;
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = LONG_HOLD;
    end
    if (++mode_age >= 50) begin
      mode_age = 0;
      stall_mode = $urandom_range(0, 3);
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 9) < 3);
        2: out_stall <= ($urandom_range(0, 9) < 7);
        default: out_stall <= ~out_stall;
      endcase
    end
  end

  // result checker
  always @(posedge clk) begin
    filt_res_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (filtered_q.size() == 0) begin
        $error("filtered pixel %0d arrived with nothing expected", out_pixel);
        errors++;
      end else begin
        exp_res = filtered_q.pop_front();
        if (out_pixel !== exp_res.out_pixel) begin
          $error("out_pixel: expected %0d, got %0d", exp_res.out_pixel, out_pixel);
          errors++;
        end
        if (end_of_row !== exp_res.eor) begin
          $error("end_of_row: expected %0d, got %0d", exp_res.eor, end_of_row);
          errors++;
        end
        if (end_of_frame !== exp_res.eof) begin
          $error("end_of_frame: expected %0d, got %0d", exp_res.eof, end_of_frame);
          errors++;
        end
      end
    end
  end

  task automatic reg_write(logic [4:0] addr, logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (addr)
      ADDR_WIDTH:   sh_width = data[10:0];
      ADDR_HEIGHT:  sh_height = data[10:0];
      ADDR_DIVIDER: sh_divider = data[7:0];
      ADDR_COEF0:   sh_coef[0] = data[23:0];
      ADDR_COEF1:   sh_coef[1] = data[23:0];
      default:      sh_coef[2] = data[23:0];
    endcase
  endtask

  task automatic set_filter(int w, int h, int dv, int c0, int c1, int c2);
    reg_write(ADDR_WIDTH, w);
    reg_write(ADDR_HEIGHT, h);
    reg_write(ADDR_DIVIDER, dv);
    reg_write(ADDR_COEF0, c0);
    reg_write(ADDR_COEF1, c1);
    reg_write(ADDR_COEF2, c2);
  endtask

  // wait until every request went in and every result came out, then let the
  // back end settle before touching the registers
  task automatic wait_idle();
    while (pending_pix.size() > 0 || in_valid || filtered_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    phases_run++;
  endtask

  // one well-formed frame of random content; a few early flushes and late pixels
  task automatic queue_frame(int w, int h);
    pix_req_t q;
    int ew, eh;
    ew = (w < 1) ? 1 : (w > MAX_WIDTH_DEF ? MAX_WIDTH_DEF : w);
    eh = (h < 1) ? 1 : (h > HEIGHT_CAP ? HEIGHT_CAP : h);
    for (int i = 0; i < ew * eh; i++) begin
      q.pixel = $urandom_range(0, 255);
      q.kind = ($urandom_range(0, 39) == 0) ? KIND_FLUSH : KIND_PIXEL;
      pending_pix.push_back(q);
    end
    for (int i = 0; i < ew + 1; i++) begin
      q.pixel = $urandom_range(0, 255);
      q.kind = ($urandom_range(0, 19) == 0) ? KIND_PIXEL : KIND_FLUSH;
      pending_pix.push_back(q);
    end
    frames_sent++;
  endtask

  function automatic logic [23:0] rand_column(bit mild);
    logic [23:0] col;
    for (int r = 0; r < 3; r++)
      col[8*r +: 8] = mild ? 8'($signed($urandom_range(0, 12)) - 4) : 8'($urandom_range(0, 255));
    return col;
  endfunction

  initial begin
    int w, h, dv, sent;
    pix_req_t q;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // 3x2 frame, max positive coefficients, coefficient-sum divide, pixel extremes
    set_filter(3, 2, 0, 24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F);
    for (int i = 0; i < 6; i++) begin
      q.kind = KIND_PIXEL;
      q.pixel = (i % 2) ? 8'h00 : 8'hFF;
      pending_pix.push_back(q);
    end
    // flushes carrying a nonzero pixel field, and one late pixel
    for (int i = 0; i < 4; i++) begin
      q.kind = (i == 2) ? KIND_PIXEL : KIND_FLUSH;
      q.pixel = 8'hFF;
      pending_pix.push_back(q);
    end
    frames_sent++;
    wait_idle();

    // zero sizes act as 1x1, most negative coefficients, divider of one
    set_filter(0, 0, 1, 24'h808080, 24'h808080, 24'h808080);
    q.kind = KIND_PIXEL;
    q.pixel = 8'hFF;
    pending_pix.push_back(q);
    queue_frame(1, 1);
    wait_idle();

    // coefficient sum of one or less: no division; early flush inside the frame
    set_filter(2, 2, 0, 24'h000100, 24'h00FF01, 24'h000000);
    q.kind = KIND_PIXEL;  q.pixel = 8'd200; pending_pix.push_back(q);
    q.kind = KIND_FLUSH;  q.pixel = 8'd77;  pending_pix.push_back(q);
    q.kind = KIND_PIXEL;  q.pixel = 8'd255; pending_pix.push_back(q);
    q.kind = KIND_PIXEL;  q.pixel = 8'd1;   pending_pix.push_back(q);
    for (int i = 0; i < 3; i++) begin
      q.kind = KIND_FLUSH; q.pixel = 8'd0; pending_pix.push_back(q);
    end
    frames_sent++;
    wait_idle();

    // random frames; the first phase sees a long hold-off on the result side
    sent = 0;
    while (sent < 620) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      h = $urandom_range(1, 6);
      case ($urandom_range(0, 3))
        0: dv = 0;
        1: dv = 1;
        2: dv = 255;
        default: dv = $urandom_range(0, 255);
      endcase
      set_filter(w, h, dv, rand_column($urandom_range(0, 1)),
                 rand_column($urandom_range(0, 1)), rand_column($urandom_range(0, 1)));
      if (phases_run == 3) hold_req++;
      for (int f = $urandom_range(1, 3); f > 0; f--) begin
        queue_frame(w, h);
        sent += w * h + w + 1;
      end
      // occasional stray requests leave the next frame out of step
      if ($urandom_range(0, 7) == 0) begin
        for (int i = $urandom_range(1, 5); i > 0; i--) begin
          q.kind = $urandom_range(0, 1);
          q.pixel = $urandom_range(0, 255);
          pending_pix.push_back(q);
          sent++;
        end
      end
      wait_idle();
    end

    $display("covered %0d frames over %0d register settings, %0d filtered pixels checked",
             frames_sent, phases_run, results_seen);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #60000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
